// ===== hw/rtl/phase_current_offset_calibrator_unit_defines.svh =====
// assertion macros for the rtl
`ifndef PHASE_CURRENT_OFFSET_CALIBRATOR_UNIT_DEFINES_SVH
`define PHASE_CURRENT_OFFSET_CALIBRATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PCOC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCOC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must never hold
`define PCOC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/pcoc_pkg.sv =====
package pcoc_pkg;

    localparam int ADC_BITS_DEF  = 12;
    localparam int CAL_SHIFT_DEF = 10;
    localparam int PHASES_DEF    = 3;

    localparam int NUM_LANES  = 3;
    localparam int CODE_IN_W  = 12;
    localparam int GAIN_W     = 24;
    localparam int CUR_W      = 37;
    localparam int TEMP_W     = 36;
    localparam int DIFF_W     = CODE_IN_W + 1;
    localparam int REG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [REG_IDX_W-1:0] REG_NOMINAL_BIAS_CODE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMPS_PER_LSB       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_VOLTS_PER_LSB = 2'd2;

    localparam logic CMD_CONVERT   = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    localparam logic [CODE_IN_W-1:0] NOMINAL_BIAS_RST  = 12'd2048;
    localparam logic [GAIN_W-1:0]    AMPS_PER_LSB_RST  = 24'd8389;
    localparam logic [GAIN_W-1:0]    TEMP_PER_LSB_RST  = 24'd845;

    typedef logic [DIFF_W-1:0] diff_t;

    typedef struct packed {
        logic active;
        logic finished;
    } cal_status_t;

    typedef struct packed {
        logic calibrating;
        logic offset_valid;
    } cal_flags_t;

endpackage

// ===== hw/rtl/pcoc_sample_if.sv =====
interface pcoc_sample_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [pcoc_pkg::CODE_IN_W-1:0]   adc_a;
    logic [pcoc_pkg::CODE_IN_W-1:0]   adc_b;
    logic [pcoc_pkg::CODE_IN_W-1:0]   adc_c;
    logic [pcoc_pkg::CODE_IN_W-1:0]   temp_raw;

    modport source (output valid, command, adc_a, adc_b, adc_c, temp_raw, input ready);
    modport sink (input valid, command, adc_a, adc_b, adc_c, temp_raw, output ready);
endinterface

// ===== hw/rtl/pcoc_result_if.sv =====
interface pcoc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcoc_pkg::CUR_W-1:0]   current_a;
    logic signed [pcoc_pkg::CUR_W-1:0]   current_b;
    logic signed [pcoc_pkg::CUR_W-1:0]   current_c;
    logic [pcoc_pkg::TEMP_W-1:0]         temp_volts;
    logic                                calibrating;
    logic                                offset_valid;

    modport source (output valid, current_a, current_b, current_c, temp_volts,
                    calibrating, offset_valid, input ready);
    modport sink (input valid, current_a, current_b, current_c, temp_volts,
                  calibrating, offset_valid, output ready);
endinterface

// ===== hw/rtl/pcoc_cal.sv =====
module pcoc_cal #(
    parameter int ADC_BITS  = pcoc_pkg::ADC_BITS_DEF,
    parameter int CAL_SHIFT = pcoc_pkg::CAL_SHIFT_DEF,
    parameter int PHASES    = pcoc_pkg::PHASES_DEF
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    step,
    input  logic                                                    restart,
    input  logic [pcoc_pkg::NUM_LANES-1:0][pcoc_pkg::CODE_IN_W-1:0] codes,
    input  logic [pcoc_pkg::CODE_IN_W-1:0]                          nominal_bias,
    output pcoc_pkg::diff_t [pcoc_pkg::NUM_LANES-1:0]               diffs,
    output pcoc_pkg::cal_flags_t                                    flags,
    output pcoc_pkg::cal_status_t                                   status
);

    localparam int NPH    = (PHASES < pcoc_pkg::NUM_LANES) ? PHASES : pcoc_pkg::NUM_LANES;
    localparam int CODE_W = (ADC_BITS < pcoc_pkg::CODE_IN_W) ? ADC_BITS : pcoc_pkg::CODE_IN_W;
    localparam int SUM_W  = CODE_W + CAL_SHIFT;
    localparam int CNT_W  = CAL_SHIFT + 1;
    localparam logic [CNT_W-1:0] CNT_DONE = {1'b1, {CAL_SHIFT{1'b0}}};

    logic              requested_reg;
    logic              active_reg;
    logic              finished_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg    [NPH];
    logic [CODE_W-1:0] offset_reg [NPH];

    logic              run;
    logic              done;
    logic [CNT_W-1:0]  count_next;
    logic [SUM_W-1:0]  sum_next   [NPH];

    // a run goes on while requested or active and no offsets are learned yet
    assign run        = !finished_reg && (requested_reg || active_reg);
    assign count_next = (active_reg ? count_reg : '0) + CNT_W'(1);
    assign done       = run && (count_next == CNT_DONE);

    assign flags.calibrating  = run && !done;
    assign flags.offset_valid = finished_reg;
    assign status.active      = active_reg;
    assign status.finished    = finished_reg;

    for (genvar i = 0; i < pcoc_pkg::NUM_LANES; i++)
    begin : g_lane
        if (i < NPH)
        begin : g_used
            logic [CODE_W-1:0]              code;
            logic [pcoc_pkg::CODE_IN_W-1:0] zero;
            logic [SUM_W-1:0]               shifted;

            assign code        = codes[i][CODE_W-1:0];
            assign zero        = finished_reg ? pcoc_pkg::CODE_IN_W'(offset_reg[i])
                                              : nominal_bias;
            assign diffs[i]    = pcoc_pkg::DIFF_W'(code) - pcoc_pkg::DIFF_W'(zero);
            // a fresh run starts from an empty sum
            assign sum_next[i] = (active_reg ? sum_reg[i] : '0) + SUM_W'(code);
            assign shifted     = sum_next[i] >> CAL_SHIFT;

            always_ff @(posedge clk)
            begin
                if (step && run)
                begin
                    sum_reg[i] <= sum_next[i];
                end
                if (step && done)
                begin
                    offset_reg[i] <= shifted[CODE_W-1:0];
                end
            end
        end
        else
        begin : g_unused
            assign diffs[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_reg <= 1'b1;
            active_reg    <= 1'b0;
            finished_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else if (restart)
        begin
            requested_reg <= 1'b1;
            active_reg    <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else if (step && run)
        begin
            requested_reg <= 1'b0;
            active_reg    <= !done;
            finished_reg  <= done;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== hw/rtl/phase_current_offset_calibrator_unit.sv =====
// a convert item passes through the s1 register and then the output register to the result channel
// throughput: one item per cycle while the result side keeps up; a calibrate request gives no result
// the rate is set by the two-stage pipe (zero-point subtract, then the gain multipliers)
// reset: gains and nominal bias take their reset values, no offsets are learned, and
// an offset averaging run starts with the first convert item after reset
`include "phase_current_offset_calibrator_unit_defines.svh"

module phase_current_offset_calibrator_unit #(
    parameter int ADC_BITS  = pcoc_pkg::ADC_BITS_DEF,
    parameter int CAL_SHIFT = pcoc_pkg::CAL_SHIFT_DEF,
    parameter int PHASES    = pcoc_pkg::PHASES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [pcoc_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [pcoc_pkg::CFG_DATA_W-1:0]   wr_data,
    pcoc_sample_if.sink                       sample,
    pcoc_result_if.source                     result
);

    localparam int PROD_W = pcoc_pkg::DIFF_W + pcoc_pkg::GAIN_W + 1;

    logic [pcoc_pkg::CODE_IN_W-1:0] nominal_reg;
    logic [pcoc_pkg::GAIN_W-1:0]    amps_reg;
    logic [pcoc_pkg::GAIN_W-1:0]    temp_gain_reg;

    logic                                         s1_valid_reg;
    pcoc_pkg::diff_t [pcoc_pkg::NUM_LANES-1:0]    s1_diff_reg;
    logic [pcoc_pkg::CODE_IN_W-1:0]               s1_temp_reg;
    pcoc_pkg::cal_flags_t                         s1_flags_reg;

    logic                                         out_valid_reg;
    logic signed [pcoc_pkg::CUR_W-1:0]            cur_reg [pcoc_pkg::NUM_LANES];
    logic [pcoc_pkg::TEMP_W-1:0]                  temp_reg;
    pcoc_pkg::cal_flags_t                         out_flags_reg;

    logic                                         s2_en;
    logic                                         in_ready;
    logic                                         accept;
    logic                                         step;
    logic                                         restart;
    logic [pcoc_pkg::NUM_LANES-1:0][pcoc_pkg::CODE_IN_W-1:0] codes;
    pcoc_pkg::diff_t [pcoc_pkg::NUM_LANES-1:0]    diffs;
    pcoc_pkg::cal_flags_t                         flags;
    pcoc_pkg::cal_status_t                        cal_st;
    logic signed [PROD_W-1:0]                     prod [pcoc_pkg::NUM_LANES];
    logic [pcoc_pkg::TEMP_W-1:0]                  temp_prod;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg   <= pcoc_pkg::NOMINAL_BIAS_RST;
            amps_reg      <= pcoc_pkg::AMPS_PER_LSB_RST;
            temp_gain_reg <= pcoc_pkg::TEMP_PER_LSB_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                pcoc_pkg::REG_NOMINAL_BIAS_CODE:
                    nominal_reg <= wr_data[pcoc_pkg::CODE_IN_W-1:0];
                pcoc_pkg::REG_AMPS_PER_LSB:
                    amps_reg <= wr_data[pcoc_pkg::GAIN_W-1:0];
                pcoc_pkg::REG_TEMP_VOLTS_PER_LSB:
                    temp_gain_reg <= wr_data[pcoc_pkg::GAIN_W-1:0];
                default:
                    nominal_reg <= nominal_reg;
            endcase
        end
    end

    // handshake: the input side is held only while s1 is full and a result waits at the output
    assign s2_en        = !out_valid_reg || result.ready;
    assign in_ready     = !s1_valid_reg || s2_en;
    assign sample.ready = in_ready;
    assign accept       = sample.valid && in_ready;
    assign step         = accept && (sample.command == pcoc_pkg::CMD_CONVERT);
    assign restart      = accept && (sample.command == pcoc_pkg::CMD_CALIBRATE);

    assign codes[0] = sample.adc_a;
    assign codes[1] = sample.adc_b;
    assign codes[2] = sample.adc_c;

    pcoc_cal #(
        .ADC_BITS  (ADC_BITS),
        .CAL_SHIFT (CAL_SHIFT),
        .PHASES    (PHASES)
    ) u_cal (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .restart      (restart),
        .codes        (codes),
        .nominal_bias (nominal_reg),
        .diffs        (diffs),
        .flags        (flags),
        .status       (cal_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= step;
            end
            if (s2_en)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_diff_reg  <= diffs;
            s1_temp_reg  <= sample.temp_raw;
            s1_flags_reg <= flags;
        end
    end

    for (genvar i = 0; i < pcoc_pkg::NUM_LANES; i++)
    begin : g_mul
        assign prod[i] = $signed(s1_diff_reg[i]) * $signed({1'b0, amps_reg});

        always_ff @(posedge clk)
        begin
            if (s2_en && s1_valid_reg)
            begin
                cur_reg[i] <= prod[i][pcoc_pkg::CUR_W-1:0];
            end
        end
    end

    assign temp_prod = pcoc_pkg::TEMP_W'(s1_temp_reg) * pcoc_pkg::TEMP_W'(temp_gain_reg);

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            temp_reg      <= temp_prod;
            out_flags_reg <= s1_flags_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.current_a    = cur_reg[0];
    assign result.current_b    = cur_reg[1];
    assign result.current_c    = cur_reg[2];
    assign result.temp_volts   = temp_reg;
    assign result.calibrating  = out_flags_reg.calibrating;
    assign result.offset_valid = out_flags_reg.offset_valid;

    `PCOC_ASSERT_NEVER(a_run_and_done, clk, rst_n, cal_st.active && cal_st.finished,
        "calibration run active while offsets are marked learned")
    `PCOC_ASSERT_IMP(a_learned_not_running, clk, rst_n,
        out_valid_reg && out_flags_reg.offset_valid, !out_flags_reg.calibrating,
        "result used learned offsets but reports a running calibration")
    `PCOC_ASSERT_NXT(a_request_clears, clk, rst_n, restart,
        !cal_st.active && !cal_st.finished,
        "calibration request did not discard the run and offsets")

endmodule
